/* hdl/srfp_pkg.sv */
`default_nettype none
package srfp_pkg;

   // Framing bytes and fixed block codes of a system-exclusive request.
   localparam logic [7:0] SX_START        = 8'hF0;
   localparam logic [7:0] SX_END          = 8'hF7;
   localparam logic [7:0] SX_BLOCK_CAPS   = 8'd6;
   localparam logic [7:0] SX_BLOCK_STRING = 8'd7;

   // Response kinds reported with each result item.
   localparam logic [2:0] KIND_NONE       = 3'd0;
   localparam logic [2:0] KIND_IDENTITY   = 3'd1;
   localparam logic [2:0] KIND_DESCRIPTOR = 3'd2;
   localparam logic [2:0] KIND_CAPS       = 3'd3;
   localparam logic [2:0] KIND_STRING_V1  = 3'd4;
   localparam logic [2:0] KIND_STRING_V2  = 3'd5;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 7;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MANUFACTURER = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAMILY       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REQ_DIR      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDENTITY     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DESCRIPTOR   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_VER   = 3'd5;

   // Packed result width and the byte-aligned stream width.
   localparam int RESULT_WIDTH   = 30;
   localparam int RSP_DATA_WIDTH = 32;

   typedef struct packed {
      logic [6:0] manufacturer_code;
      logic [6:0] family_code;
      logic [6:0] request_direction_code;
      logic [6:0] identity_block_code;
      logic [6:0] descriptor_block_code;
      logic       use_second_version;
   } cfg_type;

   // Field order is highest bit first, so the last field lands in bit 0.
   typedef struct packed {
      logic       too_long;
      logic [2:0] response_kind;
      logic [6:0] channel_number;
      logic       has_channel;
      logic [7:0] direction_code;
      logic [7:0] block_code;
      logic       request_valid;
      logic       well_formed;
   } result_type;

endpackage
`default_nettype wire

/* hdl/sysex_request_frame_parser_top.sv */
`default_nettype none
// SysEx request frame parser.
// The req channel carries one message byte per item in req_tdata, with
// req_tlast set on the final byte. For each message exactly one result item
// leaves on the rsp channel, produced by its last byte; other bytes make none.
// Throughput is one byte per cycle while no result waits with rsp_tready low.
// A byte passes through the input register, where the parser reads it, and
// a last byte's result is loaded into the result register behind rsp_tvalid.
// The csr port writes one configuration register per cycle with csr_we high;
// indexes above the register list are ignored. Write it only while idle.
// Reset (synchronous, active high) empties both registers, rearms the message
// state and restores the register defaults. While a result waits with
// rsp_tready low, the whole two-stage path holds and req_tready is low; a
// byte is never dropped and a result is never overwritten.
module sysex_request_frame_parser_top #(
   parameter int MAX_MESSAGE = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Bits: [7:0] rx_byte.
   input  wire logic [7:0]                             req_tdata,
   input  wire logic                                   req_tlast,
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   // Bits: [0] well_formed, [1] request_valid, [9:2] block_code,
   // [17:10] direction_code, [18] has_channel, [25:19] channel_number,
   // [28:26] response_kind, [29] too_long, [31:30] zero.
   output      logic [srfp_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   input  wire logic                                   csr_we,
   input  wire logic [srfp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [srfp_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   srfp_pkg::cfg_type    cfg_ff;
   srfp_pkg::result_type result;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff;
   logic [srfp_pkg::RESULT_WIDTH-1:0] rsp_data_ff;
   logic       stall;
   logic       step;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.manufacturer_code      <= 7'd125;
         cfg_ff.family_code            <= 7'd0;
         cfg_ff.request_direction_code <= 7'd0;
         cfg_ff.identity_block_code    <= 7'd1;
         cfg_ff.descriptor_block_code  <= 7'd2;
         cfg_ff.use_second_version     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            srfp_pkg::CSR_MANUFACTURER: cfg_ff.manufacturer_code      <= csr_wdata;
            srfp_pkg::CSR_FAMILY:       cfg_ff.family_code            <= csr_wdata;
            srfp_pkg::CSR_REQ_DIR:      cfg_ff.request_direction_code <= csr_wdata;
            srfp_pkg::CSR_IDENTITY:     cfg_ff.identity_block_code    <= csr_wdata;
            srfp_pkg::CSR_DESCRIPTOR:   cfg_ff.descriptor_block_code  <= csr_wdata;
            srfp_pkg::CSR_SECOND_VER:   cfg_ff.use_second_version     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The path moves as one unit unless a result is waiting to be taken.
   assign stall      = rsp_valid_ff && !rsp_tready;
   assign step       = in_valid_ff && !stall;
   assign req_tready = !stall;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!stall) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   srfp_parser #(
      .MAX_MESSAGE(MAX_MESSAGE)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .rx_byte(in_byte_ff),
      .is_last(in_last_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Result register, loaded by the last byte of a message.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!stall) begin
         rsp_valid_ff <= step && in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(srfp_pkg::RSP_DATA_WIDTH - srfp_pkg::RESULT_WIDTH){1'b0}},
                        rsp_data_ff};

   // A last byte that leaves the input register always becomes a result item.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && !stall) |=> rsp_tvalid)
      else $error("last byte did not produce a result item");

   // A channel is reported only for a valid request.
   a_channel_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[18]) |-> rsp_tdata[1])
      else $error("has_channel without request_valid");

   // A response kind is named only for a valid request, and only known kinds.
   a_kind_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[28:26] != srfp_pkg::KIND_NONE)
         |-> (rsp_tdata[1] && rsp_tdata[28:26] <= srfp_pkg::KIND_STRING_V2))
      else $error("response kind set on an invalid request");

   // An overlong message is never well formed.
   a_long_not_formed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[29]) |-> !rsp_tdata[0])
      else $error("overlong message reported well formed");

endmodule
`default_nettype wire

/* hdl/srfp_parser.sv */
`default_nettype none
module srfp_parser #(
   parameter int MAX_MESSAGE = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           rx_byte,
   input  wire logic                 is_last,
   input  wire srfp_pkg::cfg_type    cfg,
   output srfp_pkg::result_type      result
);

   localparam int PosW = $clog2(MAX_MESSAGE + 1);
   localparam logic [PosW-1:0] PosMax = PosW'(MAX_MESSAGE);

   logic [PosW-1:0] pos_ff;
   logic            err_ff;
   logic [7:0]      block_ff;
   logic [7:0]      dir_ff;
   logic [7:0]      chan_ff;
   logic            chan_seen_ff;

   logic [PosW-1:0] pos_in;
   logic            err_in;
   logic [7:0]      block_in;
   logic [7:0]      dir_in;
   logic [7:0]      chan_in;
   logic            chan_seen_in;

   // Per-message state update for one byte; the last byte rearms everything.
   always_comb begin
      pos_in       = pos_ff;
      err_in       = err_ff;
      block_in     = block_ff;
      dir_in       = dir_ff;
      chan_in      = chan_ff;
      chan_seen_in = chan_seen_ff;
      if (is_last) begin
         pos_in       = '0;
         err_in       = 1'b0;
         block_in     = '0;
         dir_in       = '0;
         chan_in      = '0;
         chan_seen_in = 1'b0;
      end else begin
         if (pos_ff == PosW'(0)) begin
            if (rx_byte != srfp_pkg::SX_START) err_in = 1'b1;
         end else begin
            if (rx_byte[7]) err_in = 1'b1;
            if (pos_ff == PosW'(1) && rx_byte != {1'b0, cfg.manufacturer_code}) err_in = 1'b1;
            if (pos_ff == PosW'(2) && rx_byte != {1'b0, cfg.family_code}) err_in = 1'b1;
            if (pos_ff == PosW'(3)) block_in = rx_byte;
            if (pos_ff == PosW'(4)) dir_in = rx_byte;
            if (pos_ff == PosW'(5)) begin
               chan_in      = rx_byte;
               chan_seen_in = 1'b1;
            end
         end
         if (pos_ff < PosMax) pos_in = pos_ff + PosW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         err_ff       <= 1'b0;
         block_ff     <= '0;
         dir_ff       <= '0;
         chan_ff      <= '0;
         chan_seen_ff <= 1'b0;
      end else if (step) begin
         pos_ff       <= pos_in;
         err_ff       <= err_in;
         block_ff     <= block_in;
         dir_ff       <= dir_in;
         chan_ff      <= chan_in;
         chan_seen_ff <= chan_seen_in;
      end
   end

   logic too_long;
   logic too_short;
   logic wf;
   logic is_req;
   logic chan_block;
   logic valid;
   logic [2:0] kind;

   // Classification of the message as seen on its last byte.
   always_comb begin
      too_long   = pos_ff >= PosMax;
      too_short  = pos_ff < PosW'(5);
      wf         = !too_long && !too_short && !err_ff && rx_byte == srfp_pkg::SX_END;
      is_req     = wf && dir_ff == {1'b0, cfg.request_direction_code};
      chan_block = block_ff == srfp_pkg::SX_BLOCK_CAPS || block_ff == srfp_pkg::SX_BLOCK_STRING;
      valid      = is_req && (!chan_block || chan_seen_ff);
      kind       = srfp_pkg::KIND_NONE;
      if (valid) begin
         if (block_ff == {1'b0, cfg.identity_block_code}) begin
            kind = srfp_pkg::KIND_IDENTITY;
         end else if (block_ff == {1'b0, cfg.descriptor_block_code}) begin
            kind = srfp_pkg::KIND_DESCRIPTOR;
         end else if (block_ff == srfp_pkg::SX_BLOCK_CAPS) begin
            kind = srfp_pkg::KIND_CAPS;
         end else if (block_ff == srfp_pkg::SX_BLOCK_STRING) begin
            kind = cfg.use_second_version ? srfp_pkg::KIND_STRING_V2
                                          : srfp_pkg::KIND_STRING_V1;
         end
      end
      result.well_formed    = wf;
      result.request_valid  = valid;
      result.block_code     = block_ff;
      result.direction_code = dir_ff;
      result.has_channel    = valid && chan_block;
      result.channel_number = (valid && chan_block) ? chan_ff[6:0] : 7'd0;
      result.response_kind  = kind;
      result.too_long       = too_long;
   end

endmodule
`default_nettype wire
